// ===== rtl/dltq_pkg.sv =====
// ----------------------------------------------------------------------------
// dltq_pkg
// Shared constants, codes and controller/datapath types of the delta-list
// timer queue.
// ----------------------------------------------------------------------------
package dltq_pkg;

  localparam int DEPTH      = 16;
  localparam int ID_WIDTH   = 16;
  localparam int TIME_WIDTH = 32;
  localparam int AW         = $clog2(DEPTH);
  localparam int CW         = $clog2(DEPTH + 1);

  localparam logic [1:0] MODE_SET   = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_GET   = 2'd2;
  localparam logic [1:0] MODE_AGE   = 2'd3;

  localparam logic [2:0] KIND_CREATED  = 3'd0;
  localparam logic [2:0] KIND_EXPIRED  = 3'd1;
  localparam logic [2:0] KIND_CLEARED  = 3'd2;
  localparam logic [2:0] KIND_TIMELEFT = 3'd3;
  localparam logic [2:0] KIND_AGEDONE  = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_ZEROID   = 2'd3;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_WALK,
    DP_SET_MARK,
    DP_SHIFT_UP,
    DP_INSERT,
    DP_CMARK,
    DP_SHIFT_DN,
    DP_CDONE,
    DP_GHIT,
    DP_AMARK,
    DP_AEXP,
    DP_IDX_CLR,
    DP_ACOPY,
    DP_ADONE,
    DP_OUT
  } dp_op_t;

  typedef enum logic [1:0] {
    ID_ZERO,
    ID_REQ,
    ID_NEW
  } idsel_t;

  typedef struct packed {
    dp_op_t     op;
    logic       res_ld;
    logic [2:0] res_kind;
    logic [1:0] res_st;
    idsel_t     res_idsel;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       full;
    logic       tid_zero;
    logic       idx_lt_cnt;
    logic       walk_ok;
    logic       id_match;
    logic       up_more;
    logic       dn_more;
    logic       emit_more;
    logic       copy_more;
    logic       out_free;
  } dp_sts_t;

endpackage

// ===== rtl/dltq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dltq_ctrl
// Request sequencer: walks the delta list one entry per cycle through the
// datapath and orders the results.
// ----------------------------------------------------------------------------
module dltq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dltq_pkg::dp_sts_t sts,
  output dltq_pkg::dp_cmd_t cmd
);
  import dltq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_SWALK, S_SSHIFT, S_CFIND, S_CSHIFT,
    S_GFIND, S_AWALK, S_AEMIT, S_ACOMP, S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd.op        = DP_NOP;
    cmd.res_ld    = 1'b0;
    cmd.res_kind  = KIND_CREATED;
    cmd.res_st    = ST_OK;
    cmd.res_idsel = ID_ZERO;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = DP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.mode)
          MODE_SET: begin
            if (sts.full) begin
              cmd.res_ld = 1'b1;
              cmd.res_st = ST_FULL;
              state_nxt  = S_EMIT;
            end else begin
              state_nxt = S_SWALK;
            end
          end
          MODE_CLEAR: begin
            if (sts.tid_zero) begin
              cmd.res_ld   = 1'b1;
              cmd.res_kind = KIND_CLEARED;
              cmd.res_st   = ST_ZEROID;
              state_nxt    = S_EMIT;
            end else begin
              state_nxt = S_CFIND;
            end
          end
          MODE_GET: begin
            if (sts.tid_zero) begin
              cmd.res_ld   = 1'b1;
              cmd.res_kind = KIND_TIMELEFT;
              cmd.res_st   = ST_ZEROID;
              state_nxt    = S_EMIT;
            end else begin
              state_nxt = S_GFIND;
            end
          end
          default: state_nxt = S_AWALK;
        endcase
      end
      S_SWALK: begin
        if (sts.idx_lt_cnt && sts.walk_ok) begin
          cmd.op = DP_WALK;
        end else begin
          cmd.op    = DP_SET_MARK;
          state_nxt = S_SSHIFT;
        end
      end
      S_SSHIFT: begin
        if (sts.up_more) begin
          cmd.op = DP_SHIFT_UP;
        end else begin
          cmd.op        = DP_INSERT;
          cmd.res_ld    = 1'b1;
          cmd.res_idsel = ID_NEW;
          state_nxt     = S_EMIT;
        end
      end
      S_CFIND: begin
        if (!sts.idx_lt_cnt) begin
          cmd.res_ld   = 1'b1;
          cmd.res_kind = KIND_CLEARED;
          cmd.res_st   = ST_NOTFOUND;
          state_nxt    = S_EMIT;
        end else if (sts.id_match) begin
          cmd.op    = DP_CMARK;
          state_nxt = S_CSHIFT;
        end else begin
          cmd.op = DP_WALK;
        end
      end
      S_CSHIFT: begin
        if (sts.dn_more) begin
          cmd.op = DP_SHIFT_DN;
        end else begin
          cmd.op        = DP_CDONE;
          cmd.res_ld    = 1'b1;
          cmd.res_kind  = KIND_CLEARED;
          cmd.res_idsel = ID_REQ;
          state_nxt     = S_EMIT;
        end
      end
      S_GFIND: begin
        if (!sts.idx_lt_cnt) begin
          cmd.res_ld   = 1'b1;
          cmd.res_kind = KIND_TIMELEFT;
          cmd.res_st   = ST_NOTFOUND;
          state_nxt    = S_EMIT;
        end else if (sts.id_match) begin
          cmd.op        = DP_GHIT;
          cmd.res_ld    = 1'b1;
          cmd.res_kind  = KIND_TIMELEFT;
          cmd.res_idsel = ID_REQ;
          state_nxt     = S_EMIT;
        end else begin
          cmd.op = DP_WALK;
        end
      end
      S_AWALK: begin
        if (sts.idx_lt_cnt && sts.walk_ok) begin
          cmd.op = DP_WALK;
        end else begin
          cmd.op    = DP_AMARK;
          state_nxt = S_AEMIT;
        end
      end
      S_AEMIT: begin
        if (sts.emit_more) begin
          if (sts.out_free) cmd.op = DP_AEXP;
        end else begin
          cmd.op    = DP_IDX_CLR;
          state_nxt = S_ACOMP;
        end
      end
      S_ACOMP: begin
        if (sts.copy_more) begin
          cmd.op = DP_ACOPY;
        end else begin
          cmd.op       = DP_ADONE;
          cmd.res_ld   = 1'b1;
          cmd.res_kind = KIND_AGEDONE;
          state_nxt    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.op    = DP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/dltq_dp.sv =====
// ----------------------------------------------------------------------------
// dltq_dp
// Datapath: delta/ID register file, walk pointer, remainder and sum
// registers, and the result register.
// ----------------------------------------------------------------------------
module dltq_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [1:0]                         in_mode,
  input  logic [dltq_pkg::TIME_WIDTH-1:0]    in_delay,
  input  logic [dltq_pkg::ID_WIDTH-1:0]      in_timer_id,
  input  logic [dltq_pkg::TIME_WIDTH-1:0]    in_elapsed,
  input  dltq_pkg::dp_cmd_t                  cmd,
  output dltq_pkg::dp_sts_t                  sts,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [2:0]                         out_kind,
  output logic [dltq_pkg::ID_WIDTH-1:0]      out_result_id,
  output logic [dltq_pkg::TIME_WIDTH-1:0]    out_time_left,
  output logic [1:0]                         out_status,
  output logic [dltq_pkg::TIME_WIDTH-1:0]    out_next_delay,
  output logic                               out_queue_empty,
  output logic                               out_last
);
  import dltq_pkg::*;

  localparam int TW = TIME_WIDTH;
  localparam int IW = ID_WIDTH;

  logic [TW-1:0] dmem [DEPTH];
  logic [IW-1:0] imem [DEPTH];

  logic [1:0]    mode_r;
  logic [IW-1:0] tid_r, idc_r;
  logic [TW-1:0] rem_r, acc_r, sav_r, hd_r, nd_r, tl_r;
  logic [CW-1:0] cnt_r, idx_r, pos_r;
  logic          emp_r;
  logic [2:0]    kind_r;
  logic [1:0]    st_r;
  logic [IW-1:0] rid_r;

  logic          ov_r;
  logic [2:0]    okind_r;
  logic [IW-1:0] oid_r;
  logic [TW-1:0] otl_r, ond_r;
  logic [1:0]    ost_r;
  logic          oemp_r, olast_r;

  logic [AW-1:0] rd_addr, wr_addr;
  logic [TW-1:0] rd_d, wr_d;
  logic [IW-1:0] rd_id, wr_id, nid;
  logic          wr_en;
  logic [CW:0]   copy_src;
  logic          lt;
  logic          out_free;

  function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a, input logic [TW-1:0] b);
    logic [TW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TW] ? {TW{1'b1}} : s[TW-1:0];
  endfunction

  assign copy_src = {1'b0, idx_r} + {1'b0, pos_r};
  assign lt       = (idx_r < cnt_r);
  assign out_free = !ov_r || out_ready;
  assign nid      = (idc_r + IW'(1) == '0) ? IW'(1) : idc_r + IW'(1);

  always_comb begin
    unique case (cmd.op)
      DP_SHIFT_UP: rd_addr = AW'(idx_r - CW'(1));
      DP_SHIFT_DN: rd_addr = AW'(idx_r + CW'(1));
      DP_ACOPY:    rd_addr = copy_src[AW-1:0];
      default:     rd_addr = idx_r[AW-1:0];
    endcase
  end
  assign rd_d  = dmem[rd_addr];
  assign rd_id = imem[rd_addr];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r[AW-1:0];
    wr_d    = rd_d;
    wr_id   = rd_id;
    unique case (cmd.op)
      DP_SHIFT_UP: begin
        wr_en = 1'b1;
        // the entry the new timer lands in front of gives up the remainder
        if (idx_r - CW'(1) == pos_r) wr_d = rd_d - rem_r;
      end
      DP_INSERT: begin
        wr_en   = 1'b1;
        wr_addr = pos_r[AW-1:0];
        wr_d    = rem_r;
        wr_id   = idc_r;
      end
      DP_SHIFT_DN: begin
        wr_en = 1'b1;
        if (idx_r == pos_r) wr_d = sat_add(rd_d, sav_r);
      end
      DP_AMARK: begin
        wr_en = lt;
        wr_d  = rd_d - rem_r;
      end
      DP_ACOPY: wr_en = 1'b1;
      default:  wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      dmem[wr_addr] <= wr_d;
      imem[wr_addr] <= wr_id;
      if (wr_addr == '0) hd_r <= wr_d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idc_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      unique case (cmd.op)
        DP_LOAD: begin
          mode_r <= in_mode;
          tid_r  <= in_timer_id;
          rem_r  <= (in_mode == MODE_AGE) ? in_elapsed : in_delay;
          idx_r  <= '0;
          acc_r  <= '0;
        end
        DP_WALK: begin
          rem_r <= rem_r - rd_d;
          acc_r <= sat_add(acc_r, rd_d);
          idx_r <= idx_r + CW'(1);
        end
        DP_SET_MARK: begin
          pos_r <= idx_r;
          idx_r <= cnt_r;
          idc_r <= nid;
        end
        DP_SHIFT_UP: idx_r <= idx_r - CW'(1);
        DP_INSERT:   cnt_r <= cnt_r + CW'(1);
        DP_CMARK: begin
          pos_r <= idx_r;
          sav_r <= rd_d;
        end
        DP_SHIFT_DN: idx_r <= idx_r + CW'(1);
        DP_CDONE:    cnt_r <= cnt_r - CW'(1);
        DP_AMARK: begin
          pos_r <= idx_r;
          nd_r  <= lt ? rd_d - rem_r : '0;
          emp_r <= !lt;
          idx_r <= '0;
        end
        DP_AEXP:    idx_r <= idx_r + CW'(1);
        DP_IDX_CLR: idx_r <= '0;
        DP_ACOPY:   idx_r <= idx_r + CW'(1);
        DP_ADONE:   cnt_r <= cnt_r - pos_r;
        default: ;
      endcase

      if (cmd.op == DP_OUT || cmd.op == DP_AEXP) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // result staging and output register
  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      kind_r <= cmd.res_kind;
      st_r   <= cmd.res_st;
      tl_r   <= (cmd.op == DP_GHIT) ? sat_add(acc_r, rd_d) : '0;
      case (cmd.res_idsel)
        ID_REQ:  rid_r <= tid_r;
        ID_NEW:  rid_r <= idc_r;
        default: rid_r <= '0;
      endcase
    end
    if (cmd.op == DP_AEXP) begin
      okind_r <= KIND_EXPIRED;
      oid_r   <= rd_id;
      otl_r   <= '0;
      ost_r   <= ST_OK;
      ond_r   <= nd_r;
      oemp_r  <= emp_r;
      olast_r <= 1'b0;
    end else if (cmd.op == DP_OUT) begin
      okind_r <= kind_r;
      oid_r   <= rid_r;
      otl_r   <= tl_r;
      ost_r   <= st_r;
      ond_r   <= (cnt_r == '0) ? '0 : hd_r;
      oemp_r  <= (cnt_r == '0);
      olast_r <= 1'b1;
    end
  end

  assign sts.mode       = mode_r;
  assign sts.full       = (cnt_r == CW'(DEPTH));
  assign sts.tid_zero   = (tid_r == '0);
  assign sts.idx_lt_cnt = lt;
  assign sts.walk_ok    = (rem_r >= rd_d);
  assign sts.id_match   = (rd_id == tid_r);
  assign sts.up_more    = (idx_r > pos_r);
  assign sts.dn_more    = ({1'b0, idx_r} + (CW+1)'(1) < {1'b0, cnt_r});
  assign sts.emit_more  = (idx_r < pos_r);
  assign sts.copy_more  = (copy_src < {1'b0, cnt_r});
  assign sts.out_free   = out_free;

  assign out_valid       = ov_r;
  assign out_kind        = okind_r;
  assign out_result_id   = oid_r;
  assign out_time_left   = otl_r;
  assign out_status      = ost_r;
  assign out_next_delay  = ond_r;
  assign out_queue_empty = oemp_r;
  assign out_last        = olast_r;

endmodule

// ===== rtl/delta_list_timer_queue_core.sv =====
// ----------------------------------------------------------------------------
// delta_list_timer_queue_core
// Callout queue of up to DEPTH timers kept as a delta-sorted list.
// ----------------------------------------------------------------------------
// Usage: one request enters on in_* (valid/ready). mode selects set, clear,
// get or age. Each request gives one result on out_*, except age, which
// gives one expired result per fired timer and then an age-done result;
// out_last marks the final result of a request. Every result carries the
// head delta and empty flag as they stand after the whole request.
// Timing: one request at a time, walked one list entry per cycle through a
// register file with one read and one write port. The sequencer stays busy
// while a set walks, shifts the tail up and inserts, a clear finds, shifts
// down and closes the gap, a get finds, or an age walks, emits the expired
// timers and compacts the list, and until the last result is handed over.
// in_ready is high only while the sequencer is idle; a finished result may
// still sit in the output register while the next request is taken.
// When the receiver stalls, the result holds and the walk waits at the next
// result. Reset empties the queue and restarts IDs at 1; no clearing pass.
// ----------------------------------------------------------------------------
module delta_list_timer_queue_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_mode,
  input  logic [dltq_pkg::TIME_WIDTH-1:0] in_delay,
  input  logic [dltq_pkg::ID_WIDTH-1:0]   in_timer_id,
  input  logic [dltq_pkg::TIME_WIDTH-1:0] in_elapsed,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      out_kind,
  output logic [dltq_pkg::ID_WIDTH-1:0]   out_result_id,
  output logic [dltq_pkg::TIME_WIDTH-1:0] out_time_left,
  output logic [1:0]                      out_status,
  output logic [dltq_pkg::TIME_WIDTH-1:0] out_next_delay,
  output logic                            out_queue_empty,
  output logic                            out_last
);
  import dltq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  dltq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dltq_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mode         (in_mode),
    .in_delay        (in_delay),
    .in_timer_id     (in_timer_id),
    .in_elapsed      (in_elapsed),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_result_id   (out_result_id),
    .out_time_left   (out_time_left),
    .out_status      (out_status),
    .out_next_delay  (out_next_delay),
    .out_queue_empty (out_queue_empty),
    .out_last        (out_last)
  );

endmodule

// ===== rtl/dltq_checker.sv =====
// ----------------------------------------------------------------------------
// dltq_port_checks
// Port-level checks of the timer queue, bound to the top level.
// ----------------------------------------------------------------------------
module dltq_port_checks (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [2:0]                      out_kind,
  input logic [dltq_pkg::ID_WIDTH-1:0]   out_result_id,
  input logic [dltq_pkg::TIME_WIDTH-1:0] out_time_left,
  input logic [dltq_pkg::TIME_WIDTH-1:0] out_next_delay,
  input logic                            out_queue_empty,
  input logic                            out_last
);
  import dltq_pkg::*;

  // one request in flight: taking a request drops ready
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");

  a_exp_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_EXPIRED |-> !out_last)
    else $error("expired result marked last");

  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_queue_empty |-> out_next_delay == '0)
    else $error("empty queue with nonzero head delay");

  a_tl_only_get: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_TIMELEFT |-> out_time_left == '0)
    else $error("time left on a non-query result");

  a_agedone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_AGEDONE |-> out_last && out_result_id == '0)
    else $error("malformed age-done result");

endmodule

bind delta_list_timer_queue_core dltq_port_checks u_dltq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_kind        (out_kind),
  .out_result_id   (out_result_id),
  .out_time_left   (out_time_left),
  .out_next_delay  (out_next_delay),
  .out_queue_empty (out_queue_empty),
  .out_last        (out_last)
);

// ===== bench/dltq_checker.sv =====
// ----------------------------------------------------------------------------
// dltq_checker
// Watches the request and result channels of the timer queue, keeps its own
// delta list, predicts the results of every accepted request and compares.
// ----------------------------------------------------------------------------
module dltq_checker
  import dltq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [1:0]            in_mode,
  input  logic [TIME_WIDTH-1:0] in_delay,
  input  logic [ID_WIDTH-1:0]   in_timer_id,
  input  logic [TIME_WIDTH-1:0] in_elapsed,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [2:0]            out_kind,
  input  logic [ID_WIDTH-1:0]   out_result_id,
  input  logic [TIME_WIDTH-1:0] out_time_left,
  input  logic [1:0]            out_status,
  input  logic [TIME_WIDTH-1:0] out_next_delay,
  input  logic                  out_queue_empty,
  input  logic                  out_last,
  output int                    err_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]            kind;
    logic [ID_WIDTH-1:0]   rid;
    logic [TIME_WIDTH-1:0] left;
    logic [1:0]            status;
    logic [TIME_WIDTH-1:0] nxt;
    logic                  empty;
    logic                  last;
  } timer_result_t;

  logic [TIME_WIDTH-1:0] deltas [DEPTH];
  logic [ID_WIDTH-1:0]   ids    [DEPTH];
  int                    live;
  logic [ID_WIDTH-1:0]   last_id;
  timer_result_t         expected_results [$];

  assign pending = expected_results.size();

  function automatic logic [TIME_WIDTH-1:0] sat_sum(logic [TIME_WIDTH-1:0] a,
                                                    logic [TIME_WIDTH-1:0] b);
    logic [TIME_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_WIDTH] ? '1 : s[TIME_WIDTH-1:0];
  endfunction

  task automatic drop_entry(int pos);
    for (int i = pos; i + 1 < live; i++) begin
      deltas[i] = deltas[i+1];
      ids[i]    = ids[i+1];
    end
    live--;
  endtask

  task automatic predict_request(logic [1:0] mode, logic [TIME_WIDTH-1:0] dly,
                                 logic [ID_WIDTH-1:0] tid,
                                 logic [TIME_WIDTH-1:0] el);
    timer_result_t step_res [$];
    timer_result_t r;
    int pos;
    logic [TIME_WIDTH-1:0] sum;
    logic [ID_WIDTH-1:0] nid;
    r = '0;
    case (mode)
      MODE_SET: begin
        r.kind = KIND_CREATED;
        if (live >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          nid = last_id + 1'b1;
          if (nid == 0) nid = 1;
          last_id = nid;
          pos = 0;
          while (pos < live && dly >= deltas[pos]) begin
            dly -= deltas[pos];
            pos++;
          end
          if (pos < live) deltas[pos] -= dly;
          for (int i = live; i > pos; i--) begin
            deltas[i] = deltas[i-1];
            ids[i]    = ids[i-1];
          end
          deltas[pos] = dly;
          ids[pos] = nid;
          live++;
          r.rid = nid;
        end
        step_res.push_back(r);
      end
      MODE_CLEAR, MODE_GET: begin
        r.kind = (mode == MODE_CLEAR) ? KIND_CLEARED : KIND_TIMELEFT;
        if (tid == 0) begin
          r.status = ST_ZEROID;
        end else begin
          pos = live;
          sum = '0;
          for (int i = 0; i < live; i++) begin
            sum = sat_sum(sum, deltas[i]);
            if (ids[i] == tid) begin
              pos = i;
              break;
            end
          end
          if (pos >= live) begin
            r.status = ST_NOTFOUND;
          end else begin
            r.rid = tid;
            if (mode == MODE_GET) begin
              r.left = sum;
            end else begin
              if (pos + 1 < live) deltas[pos+1] = sat_sum(deltas[pos+1], deltas[pos]);
              drop_entry(pos);
            end
          end
        end
        step_res.push_back(r);
      end
      default: begin
        while (live > 0) begin
          if (deltas[0] > el) begin
            deltas[0] -= el;
            break;
          end
          el -= deltas[0];
          r = '0;
          r.kind = KIND_EXPIRED;
          r.rid = ids[0];
          step_res.push_back(r);
          drop_entry(0);
        end
        r = '0;
        r.kind = KIND_AGEDONE;
        step_res.push_back(r);
      end
    endcase
    foreach (step_res[k]) begin
      step_res[k].nxt   = (live > 0) ? deltas[0] : '0;
      step_res[k].empty = (live == 0);
      step_res[k].last  = (k == step_res.size() - 1);
      expected_results.push_back(step_res[k]);
    end
  endtask

  always @(posedge clk) begin
    timer_result_t got, want;
    if (!rst_n) begin
      live = 0;
      last_id = '0;
      err_count <= 0;
      expected_results.delete();
    end else begin
      if (in_valid && in_ready)
        predict_request(in_mode, in_delay, in_timer_id, in_elapsed);
      if (out_valid && out_ready) begin
        got = '{out_kind, out_result_id, out_time_left, out_status,
                out_next_delay, out_queue_empty, out_last};
        if (expected_results.size() == 0) begin
          if (err_count < 10) $display("unexpected result %h", got);
          err_count <= err_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            if (err_count < 10) begin
              $display("mismatch: expected kind=%0d id=%0d left=%0d st=%0d nxt=%0d e=%0b l=%0b",
                       want.kind, want.rid, want.left, want.status, want.nxt,
                       want.empty, want.last);
              $display("          actual   kind=%0d id=%0d left=%0d st=%0d nxt=%0d e=%0b l=%0b",
                       got.kind, got.rid, got.left, got.status, got.nxt,
                       got.empty, got.last);
            end
            err_count <= err_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives set, clear, get and age requests into the timer queue under several
// idling patterns; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import dltq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_mode = MODE_SET;
  logic [TIME_WIDTH-1:0] in_delay = '0;
  logic [ID_WIDTH-1:0]   in_timer_id = '0;
  logic [TIME_WIDTH-1:0] in_elapsed = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [2:0]            out_kind;
  logic [ID_WIDTH-1:0]   out_result_id;
  logic [TIME_WIDTH-1:0] out_time_left;
  logic [1:0]            out_status;
  logic [TIME_WIDTH-1:0] out_next_delay;
  logic                  out_queue_empty;
  logic                  out_last;
  int                    err_count;
  int                    pending;
  int                    send_idle_pct = 0;
  int                    recv_stall_pct = 0;
  logic [ID_WIDTH-1:0]   issued_ids [$];

  always #4 clk = ~clk;

  delta_list_timer_queue_core dut (.*);
  dltq_checker chk (.*);

  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // track IDs handed out so clears and gets mostly hit live timers
  always @(posedge clk)
    if (rst_n && out_valid && out_ready && out_kind == KIND_CREATED && out_status == ST_OK)
      issued_ids.push_back(out_result_id);

  // hold valid between back-to-back requests; drop it only while idling
  task automatic send_request(logic [1:0] mode, logic [TIME_WIDTH-1:0] dly,
                              logic [ID_WIDTH-1:0] tid, logic [TIME_WIDTH-1:0] el);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= mode;
    in_delay    <= dly;
    in_timer_id <= tid;
    in_elapsed  <= el;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic logic [ID_WIDTH-1:0] pick_id();
    int r;
    r = $urandom_range(99);
    if (r < 75 && issued_ids.size() > 0)
      return issued_ids[$urandom_range(issued_ids.size() - 1)];
    if (r < 85) return '0;
    return ID_WIDTH'($urandom);
  endfunction

  function automatic logic [TIME_WIDTH-1:0] pick_time();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return $urandom;
      default: return $urandom_range(60);
    endcase
  endfunction

  task automatic random_phase(int n);
    int r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 40) send_request(MODE_SET, pick_time(), ID_WIDTH'($urandom), $urandom);
      else if (r < 60) send_request(MODE_CLEAR, $urandom, pick_id(), $urandom);
      else if (r < 80) send_request(MODE_GET, $urandom, pick_id(), $urandom);
      else send_request(MODE_AGE, $urandom, ID_WIDTH'($urandom), pick_time());
    end
  endtask

  initial begin
    #2ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // directed: fill past full with equal and extreme delays, probe, drain
    send_request(MODE_SET, 32'd5, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(MODE_SET, 32'd5, '0, '0);
    send_request(MODE_SET, '0, '0, '0);
    send_request(MODE_SET, '1, '0, '0);
    for (int i = 0; i < 13; i++) send_request(MODE_SET, 32'd3 * i, '0, '0);
    send_request(MODE_GET, '0, 16'd4, '0);
    send_request(MODE_GET, '0, 16'd0, '0);
    send_request(MODE_GET, '0, 16'hFFFF, '0);
    send_request(MODE_CLEAR, '0, 16'd2, '0);
    send_request(MODE_CLEAR, '0, 16'd0, '0);
    send_request(MODE_CLEAR, '0, 16'd999, '0);
    send_request(MODE_AGE, '0, '0, 32'd5);
    send_request(MODE_AGE, '0, '0, '1);
    send_request(MODE_AGE, '0, '0, '0);
    random_phase(100);
    send_idle_pct = 52;
    random_phase(100);
    send_idle_pct = 0;
    recv_stall_pct = 52;
    random_phase(100);
    send_idle_pct = 23;
    recv_stall_pct = 23;
    random_phase(100);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_phase(35);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
